### src/arcade_drive_ramp_mixer_assert.svh
// Assertion macros for the arcade drive ramp mixer.
// Depends on signals named clock and reset in the including module.
`ifndef ARCADE_DRIVE_RAMP_MIXER_ASSERT_SVH
`define ARCADE_DRIVE_RAMP_MIXER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define ADRM_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("adrm same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ADRM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("adrm next-cycle check failed");

`endif

### src/adrm_pkg.sv
// Shared types, register codes and helper functions for the arcade drive ramp mixer.
// No dependencies; used by adrm_ramp_side and arcade_drive_ramp_mixer.
package adrm_pkg;

   localparam int STICK_W = 15;
   localparam int CFG_W   = 14;
   localparam int SPEED_W = 16;
   localparam int TARGET_W = 17;
   localparam int CALC_W  = 18;
   localparam int ADDR_W  = 5;
   localparam int DATA_W  = 32;

   typedef logic signed [STICK_W-1:0]  stick_type;
   typedef logic signed [SPEED_W-1:0]  speed_type;
   typedef logic signed [TARGET_W-1:0] target_type;
   typedef logic        [CFG_W-1:0]    cfg_val_type;

   typedef struct packed {
      cfg_val_type step;
      cfg_val_type limit;
   } adrm_ramp_cfg_type;

   // Register indexes (byte address / 4)
   localparam logic [2:0] REG_DEADBAND     = 3'd0;
   localparam logic [2:0] REG_MAX_SPEED    = 3'd1;
   localparam logic [2:0] REG_RAMP_STEP    = 3'd2;
   localparam logic [2:0] REG_LEFT_INVERT  = 3'd3;
   localparam logic [2:0] REG_RIGHT_INVERT = 3'd4;

   localparam cfg_val_type DEADBAND_RESET  = 14'd819;
   localparam cfg_val_type MAX_SPEED_RESET = 14'd8192;
   localparam cfg_val_type RAMP_STEP_RESET = 14'd410;

   // Zero a stick value whose magnitude is at or below the deadband.
   function automatic stick_type apply_deadband(input stick_type v, input cfg_val_type db);
      logic signed [STICK_W:0] v_x;
      logic signed [STICK_W:0] mag;
      v_x = {v[STICK_W-1], v};
      mag = v_x[STICK_W] ? -v_x : v_x;
      if (mag <= $signed({2'b00, db}))
         return '0;
      return v;
   endfunction

endpackage

### src/arcade_drive_ramp_mixer.sv
// Arcade drive ramp mixer top level: stream ports, APB register file, tick datapath.
// Depends on adrm_pkg, adrm_ramp_side and arcade_drive_ramp_mixer_assert.svh.
//
//   channel   direction  handshake           payload
//   req_      in         tvalid / tready     tdata: forward, twist; tuser: buttons
//   rsp_      out        tvalid / tready     tdata: left, right drive; tuser: gear
//   csr_      in/out     APB psel/penable    five control registers
//
// One transaction per clock sustained while rsp_tready stays high; an accepted req passes
// through the input register, then the speed/gear state that doubles as result register.
// The speed feedback loop (add, compare, clamp per side) sets the clock path.
// Reset (synchronous, active high) clears speeds, gear, valids; presets control registers.
// A stalled rsp side holds the result and fills the input register, then drops
// req_tready until the result is taken.
`include "arcade_drive_ramp_mixer_assert.svh"

module arcade_drive_ramp_mixer
   import adrm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   // request stream
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [31:0]       req_tdata,   // [14:0] forward, [29:15] twist, [31:30] zero
   input  logic [1:0]        req_tuser,   // [0] high_button, [1] low_button
   // result stream
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [31:0]       rsp_tdata,   // [14:0] left_drive, [29:15] right_drive, [31:30] 0
   output logic              rsp_tuser,   // [0] gear_is_high
   // configuration
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [DATA_W-1:0] csr_pwdata,
   output logic [DATA_W-1:0] csr_prdata,
   output logic              csr_pready
);

   // ---------------- configuration registers ----------------
   cfg_val_type deadband_ff,  deadband_in;
   cfg_val_type max_speed_ff, max_speed_in;
   cfg_val_type ramp_step_ff, ramp_step_in;
   logic        left_inv_ff,  left_inv_in;
   logic        right_inv_ff, right_inv_in;

   logic       csr_write;
   logic [2:0] csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[4:2];

   always_comb begin
      deadband_in  = deadband_ff;
      max_speed_in = max_speed_ff;
      ramp_step_in = ramp_step_ff;
      left_inv_in  = left_inv_ff;
      right_inv_in = right_inv_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_DEADBAND:     deadband_in  = csr_pwdata[CFG_W-1:0];
            REG_MAX_SPEED:    max_speed_in = csr_pwdata[CFG_W-1:0];
            REG_RAMP_STEP:    ramp_step_in = csr_pwdata[CFG_W-1:0];
            REG_LEFT_INVERT:  left_inv_in  = csr_pwdata[0];
            REG_RIGHT_INVERT: right_inv_in = csr_pwdata[0];
            default: ;  // unmapped address: drop the write
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_DEADBAND:     csr_prdata = {{(DATA_W-CFG_W){1'b0}}, deadband_ff};
         REG_MAX_SPEED:    csr_prdata = {{(DATA_W-CFG_W){1'b0}}, max_speed_ff};
         REG_RAMP_STEP:    csr_prdata = {{(DATA_W-CFG_W){1'b0}}, ramp_step_ff};
         REG_LEFT_INVERT:  csr_prdata = {{(DATA_W-1){1'b0}}, left_inv_ff};
         REG_RIGHT_INVERT: csr_prdata = {{(DATA_W-1){1'b0}}, right_inv_ff};
         default:          csr_prdata = '0;
      endcase
   end

   // ---------------- input register ----------------
   logic      s1_valid_ff, s1_valid_in;
   stick_type forward_ff,  forward_in;
   stick_type twist_ff,    twist_in;
   logic      high_btn_ff, high_btn_in;
   logic      low_btn_ff,  low_btn_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic advance;
   logic req_accept;

   // Move the held item into the state when the result slot is free or draining.
   assign advance    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      forward_in  = forward_ff;
      twist_in    = twist_ff;
      high_btn_in = high_btn_ff;
      low_btn_in  = low_btn_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
         forward_in  = req_tdata[STICK_W-1:0];
         twist_in    = req_tdata[2*STICK_W-1:STICK_W];
         high_btn_in = req_tuser[0];
         low_btn_in  = req_tuser[1];
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   // ---------------- tick datapath ----------------
   stick_type              fwd_db;
   stick_type              tw_db;
   logic signed [SPEED_W-1:0]  left_sum;
   logic signed [SPEED_W-1:0]  right_sum;
   target_type             left_target;
   target_type             right_target;
   adrm_ramp_cfg_type      ramp_cfg;

   speed_type left_speed_ff,  left_speed_in,  left_next;
   speed_type right_speed_ff, right_speed_in, right_next;
   logic      gear_high_ff,   gear_high_in;

   assign fwd_db    = apply_deadband(forward_ff, deadband_ff);
   assign tw_db     = apply_deadband(twist_ff, deadband_ff);
   assign left_sum  = {fwd_db[STICK_W-1], fwd_db} + {tw_db[STICK_W-1], tw_db};
   assign right_sum = {fwd_db[STICK_W-1], fwd_db} - {tw_db[STICK_W-1], tw_db};

   // Negate in the wider width so the most negative sum flips cleanly.
   assign left_target  = left_inv_ff  ? -{left_sum[SPEED_W-1], left_sum}
                                      :  {left_sum[SPEED_W-1], left_sum};
   assign right_target = right_inv_ff ? -{right_sum[SPEED_W-1], right_sum}
                                      :  {right_sum[SPEED_W-1], right_sum};

   assign ramp_cfg.step  = ramp_step_ff;
   assign ramp_cfg.limit = max_speed_ff;

   adrm_ramp_side u_left (
      .speed      (left_speed_ff),
      .target     (left_target),
      .cfg        (ramp_cfg),
      .next_speed (left_next)
   );

   adrm_ramp_side u_right (
      .speed      (right_speed_ff),
      .target     (right_target),
      .cfg        (ramp_cfg),
      .next_speed (right_next)
   );

   // The speed and gear state is also the result payload: update both on advance.
   always_comb begin
      left_speed_in  = left_speed_ff;
      right_speed_in = right_speed_ff;
      gear_high_in   = gear_high_ff;
      if (advance) begin
         left_speed_in  = left_next;
         right_speed_in = right_next;
         priority if (high_btn_ff) begin
            gear_high_in = 1'b1;
         end else if (low_btn_ff) begin
            gear_high_in = 1'b0;
         end else begin
            gear_high_in = gear_high_ff;
         end
      end
   end

   always_comb begin
      priority if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, right_speed_ff[STICK_W-1:0], left_speed_ff[STICK_W-1:0]};
   assign rsp_tuser  = gear_high_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff    <= DEADBAND_RESET;
         max_speed_ff   <= MAX_SPEED_RESET;
         ramp_step_ff   <= RAMP_STEP_RESET;
         left_inv_ff    <= 1'b0;
         right_inv_ff   <= 1'b1;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         left_speed_ff  <= '0;
         right_speed_ff <= '0;
         gear_high_ff   <= 1'b0;
      end else begin
         deadband_ff    <= deadband_in;
         max_speed_ff   <= max_speed_in;
         ramp_step_ff   <= ramp_step_in;
         left_inv_ff    <= left_inv_in;
         right_inv_ff   <= right_inv_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         left_speed_ff  <= left_speed_in;
         right_speed_ff <= right_speed_in;
         gear_high_ff   <= gear_high_in;
      end
   end

   // Payload: no reset needed
   always_ff @(posedge clock) begin
      forward_ff  <= forward_in;
      twist_ff    <= twist_in;
      high_btn_ff <= high_btn_in;
      low_btn_ff  <= low_btn_in;
   end

   // ---------------- assertions ----------------
   `ADRM_ASSERT_SAME(a_ready_only_when_held, !req_tready, s1_valid_ff && rsp_valid_ff)
   `ADRM_ASSERT_NEXT(a_high_button_shifts_up, advance && high_btn_ff, gear_high_ff)
   `ADRM_ASSERT_NEXT(a_zero_target_snaps, advance && (left_target == '0), left_speed_ff == '0)

endmodule

### src/adrm_ramp_side.sv
// One side of the drive: ramp the stored speed toward its target, snap, clamp.
// Depends on adrm_pkg.
module adrm_ramp_side
   import adrm_pkg::*;
(
   input  speed_type         speed,
   input  target_type        target,
   input  adrm_ramp_cfg_type cfg,
   output speed_type         next_speed
);

   logic signed [CALC_W-1:0] speed_x;
   logic signed [CALC_W-1:0] target_x;
   logic signed [CALC_W-1:0] step_x;
   logic signed [CALC_W-1:0] lim_x;
   logic signed [CALC_W-1:0] diff;
   logic signed [CALC_W-1:0] mag;
   logic signed [CALC_W-1:0] stepped;
   logic signed [CALC_W-1:0] result;

   assign speed_x  = {{(CALC_W-SPEED_W){speed[SPEED_W-1]}}, speed};
   assign target_x = {{(CALC_W-TARGET_W){target[TARGET_W-1]}}, target};
   assign step_x   = {{(CALC_W-CFG_W){1'b0}}, cfg.step};
   assign lim_x    = {{(CALC_W-CFG_W){1'b0}}, cfg.limit};
   assign diff     = target_x - speed_x;
   assign mag      = diff[CALC_W-1] ? -diff : diff;

   always_comb begin
      stepped = speed_x;
      if (mag >= step_x) begin
         priority if (diff > 0) begin
            stepped = speed_x + step_x;
         end else if (diff < 0) begin
            stepped = speed_x - step_x;
         end else begin
            stepped = speed_x;
         end
      end
      // snap to zero, then clamp to the symmetric limit
      priority if (target_x == '0) begin
         result = '0;
      end else if (stepped > lim_x) begin
         result = lim_x;
      end else if (stepped < -lim_x) begin
         result = -lim_x;
      end else begin
         result = stepped;
      end
   end

   assign next_speed = result[SPEED_W-1:0];

endmodule

### test/tb_arcade_drive_ramp_mixer.sv
// Self-checking testbench for arcade_drive_ramp_mixer: directed corners, then random stick runs.
// Depends on adrm_pkg and the arcade_drive_ramp_mixer RTL; needs no files or arguments.
`timescale 1ns / 1ps

module tb_arcade_drive_ramp_mixer;
   import adrm_pkg::*;

   // Register slots past the end of the map; writes there must be dropped.
   localparam logic [2:0] REG_SPARE_A = 3'd5;
   localparam logic [2:0] REG_SPARE_B = 3'd6;
   localparam logic [2:0] REG_SPARE_C = 3'd7;

   localparam int STICK_MIN   = -16384;
   localparam int STICK_MAX   = 16383;
   localparam int CFG_MAX     = 16383;
   localparam int QUIET_LIMIT = 5000;   // cycles with no transaction of any kind
   localparam int MAX_REPORTS = 10;
   localparam int DRAIN_TAIL  = 8;      // extra cycles after the last result

   typedef struct {
      stick_type left_drive;
      stick_type right_drive;
      logic      gear_is_high;
   } drive_cmd_type;

   logic              clock;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [31:0]       req_tdata   = '0;   // [14:0] forward, [29:15] twist, [31:30] zero
   logic [1:0]        req_tuser   = '0;   // [0] high_button, [1] low_button
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [31:0]       rsp_tdata;          // [14:0] left_drive, [29:15] right_drive, [31:30] zero
   logic              rsp_tuser;          // [0] gear_is_high
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0] csr_paddr   = '0;
   logic [DATA_W-1:0] csr_pwdata  = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   arcade_drive_ramp_mixer u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Mixer predictor: its own copy of the control registers and of the drive state.
   // ---------------------------------------------------------------------------------------
   cfg_val_type mix_deadband;
   cfg_val_type mix_max_speed;
   cfg_val_type mix_ramp_step;
   logic        mix_left_invert;
   logic        mix_right_invert;
   speed_type   mix_left_speed;
   speed_type   mix_right_speed;
   logic        mix_gear_high;

   drive_cmd_type pending_drive_cmds[$];   // predicted results, oldest first

   int mismatch_count = 0;
   int quiet_cycles   = 0;
   int send_idle_pct  = 0;                 // chance per cycle that the sender holds off
   int recv_stall_pct = 0;                 // chance per cycle that the receiver stalls

   task automatic reset_mixer_model();
      mix_deadband     = DEADBAND_RESET;
      mix_max_speed    = MAX_SPEED_RESET;
      mix_ramp_step    = RAMP_STEP_RESET;
      mix_left_invert  = 1'b0;
      mix_right_invert = 1'b1;
      mix_left_speed   = '0;
      mix_right_speed  = '0;
      mix_gear_high    = 1'b0;
   endtask

   // Mirror a register write; slots beyond the map change nothing.
   task automatic apply_register(input logic [2:0] idx, input logic [31:0] value);
      unique case (idx)
         REG_DEADBAND:     mix_deadband     = value[CFG_W-1:0];
         REG_MAX_SPEED:    mix_max_speed    = value[CFG_W-1:0];
         REG_RAMP_STEP:    mix_ramp_step    = value[CFG_W-1:0];
         REG_LEFT_INVERT:  mix_left_invert  = value[0];
         REG_RIGHT_INVERT: mix_right_invert = value[0];
         default: ;
      endcase
   endtask

   function automatic logic [31:0] register_value(input logic [2:0] idx);
      unique case (idx)
         REG_DEADBAND:     return {18'd0, mix_deadband};
         REG_MAX_SPEED:    return {18'd0, mix_max_speed};
         REG_RAMP_STEP:    return {18'd0, mix_ramp_step};
         REG_LEFT_INVERT:  return {31'd0, mix_left_invert};
         REG_RIGHT_INVERT: return {31'd0, mix_right_invert};
         default:          return '0;
      endcase
   endfunction

   function automatic int zero_inside_deadband(input int stick);
      int mag;
      mag = (stick < 0) ? -stick : stick;
      return (mag <= int'(mix_deadband)) ? 0 : stick;
   endfunction

   // Step one side toward its target, snap on a zero target, then clamp.
   function automatic int ramp_toward(input int speed, input int target);
      int step_v;
      int lim;
      int gap;
      int gap_mag;
      step_v  = int'(mix_ramp_step);
      lim     = int'(mix_max_speed);
      gap     = target - speed;
      gap_mag = (gap < 0) ? -gap : gap;
      if (gap_mag >= step_v) begin
         if (gap > 0)
            speed = speed + step_v;
         else if (gap < 0)
            speed = speed - step_v;
      end
      if (target == 0)
         speed = 0;
      if (speed > lim)
         speed = lim;
      if (speed < -lim)
         speed = -lim;
      return speed;
   endfunction

   // Advance the model by one accepted tick and queue the result it must produce.
   task automatic predict_tick(input stick_type fwd, input stick_type twist,
                               input logic high_btn, input logic low_btn);
      int            fwd_live;
      int            twist_live;
      int            left_target;
      int            right_target;
      drive_cmd_type cmd;
      fwd_live     = zero_inside_deadband(int'(fwd));
      twist_live   = zero_inside_deadband(int'(twist));
      left_target  = fwd_live + twist_live;
      right_target = fwd_live - twist_live;
      // High button wins over low; neither pressed keeps the gear.
      if (high_btn)
         mix_gear_high = 1'b1;
      else if (low_btn)
         mix_gear_high = 1'b0;
      if (mix_left_invert)
         left_target = -left_target;
      if (mix_right_invert)
         right_target = -right_target;
      mix_left_speed  = speed_type'(ramp_toward(int'(mix_left_speed), left_target));
      mix_right_speed = speed_type'(ramp_toward(int'(mix_right_speed), right_target));
      cmd.left_drive   = mix_left_speed[STICK_W-1:0];
      cmd.right_drive  = mix_right_speed[STICK_W-1:0];
      cmd.gear_is_high = mix_gear_high;
      pending_drive_cmds.push_back(cmd);
   endtask

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // ---------------------------------------------------------------------------------------
   // Result side: random back-pressure, compare every rsp transaction, watchdog.
   // Values read here are the ones present before the edge, so ordering within the
   // time step does not matter.
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin : rsp_side
      drive_cmd_type want;
      stick_type     got_left;
      stick_type     got_right;
      got_left  = rsp_tdata[STICK_W-1:0];
      got_right = rsp_tdata[2*STICK_W-1:STICK_W];
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_drive_cmds.size() == 0) begin
            note_failure($sformatf("result with no transaction pending: left %0d right %0d gear %0b",
                                   got_left, got_right, rsp_tuser));
         end else begin
            want = pending_drive_cmds.pop_front();
            if (got_left !== want.left_drive)
               note_failure($sformatf("left_drive expected %0d actual %0d",
                                      want.left_drive, got_left));
            if (got_right !== want.right_drive)
               note_failure($sformatf("right_drive expected %0d actual %0d",
                                      want.right_drive, got_right));
            if (rsp_tuser !== want.gear_is_high)
               note_failure($sformatf("gear expected %0b actual %0b",
                                      want.gear_is_high, rsp_tuser));
         end
      end

      // Count cycles in which nothing moves on any port; a hang ends the run.
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_psel)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                  QUIET_LIMIT, pending_drive_cmds.size());
         $display("TEST FAILED");
         $finish;
      end

      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ---------------------------------------------------------------------------------------
   // Request side and register access.
   // ---------------------------------------------------------------------------------------

   // Send one tick; hold off first as the sender idle rate says, then wait for the handshake.
   task automatic send_tick(input int fwd, input int twist, input bit high_btn,
                            input bit low_btn);
      stick_type fwd_bits;
      stick_type twist_bits;
      int        gap;
      fwd_bits   = fwd[STICK_W-1:0];
      twist_bits = twist[STICK_W-1:0];
      gap = 0;
      while (gap < 200 && $urandom_range(99) < send_idle_pct)
         gap++;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, twist_bits, fwd_bits};
      req_tuser  <= {low_btn, high_btn};
      do
         @(posedge clock);
      while (!req_tready);
      predict_tick(fwd_bits, twist_bits, high_btn, low_btn);
   endtask

   // Drop valid and let every expected result come back before touching registers.
   task automatic settle_block();
      req_tvalid <= 1'b0;
      while (pending_drive_cmds.size() != 0)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
      settle_block();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);          // access cycle: the register takes the value here
      apply_register(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Read a register back and compare it with the model's copy.
   task automatic check_register(input logic [2:0] idx);
      logic [31:0] got;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      if (got !== register_value(idx))
         note_failure($sformatf("register %0d readback expected %0d actual %0d",
                                idx, register_value(idx), got));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_all_registers();
      check_register(REG_DEADBAND);
      check_register(REG_MAX_SPEED);
      check_register(REG_RAMP_STEP);
      check_register(REG_LEFT_INVERT);
      check_register(REG_RIGHT_INVERT);
   endtask

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------------------------
   function automatic int full_stick();
      return int'($urandom_range(STICK_MAX - STICK_MIN)) + STICK_MIN;
   endfunction

   // Mostly in-range stick positions, with some rest positions and some anywhere across full scale.
   function automatic int pick_stick();
      int r;
      r = $urandom_range(99);
      if (r < 15)
         return 0;
      if (r < 25)
         return full_stick();
      return int'($urandom_range(16384)) - 8192;
   endfunction

   function automatic bit press();
      return ($urandom_range(99) < 8);
   endfunction

   // Pick a fresh setting for every register, reaching the extremes now and then.
   task automatic randomize_config();
      int r;
      r = $urandom_range(99);
      write_reg(REG_DEADBAND, (r < 10) ? 0 : (r < 15) ? CFG_MAX :
                              (r < 22) ? $urandom_range(CFG_MAX) : $urandom_range(1500));
      r = $urandom_range(99);
      write_reg(REG_MAX_SPEED, (r < 5) ? 0 : (r < 15) ? CFG_MAX :
                               (r < 35) ? 8192 : $urandom_range(CFG_MAX, 1000));
      r = $urandom_range(99);
      write_reg(REG_RAMP_STEP, (r < 5) ? 0 : (r < 10) ? 1 :
                               (r < 15) ? CFG_MAX : $urandom_range(2000, 1));
      write_reg(REG_LEFT_INVERT, $urandom_range(1));
      write_reg(REG_RIGHT_INVERT, $urandom_range(1));
   endtask

   // Mostly held stick positions so the speeds ramp all the way in; the rest is noise.
   task automatic run_random_segment(input int n_items);
      int sent;
      int run_len;
      int base_fwd;
      int base_twist;
      int jitter;
      randomize_config();
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 20) begin
            send_tick(full_stick(), full_stick(), $urandom_range(1), $urandom_range(1));
            sent++;
         end else begin
            base_fwd   = pick_stick();
            base_twist = ($urandom_range(3) == 0) ? 0 : pick_stick();
            run_len    = $urandom_range(30, 1);
            for (int k = 0; k < run_len && sent < n_items; k++) begin
               jitter = ($urandom_range(3) == 0) ? int'($urandom_range(64)) - 32 : 0;
               send_tick(base_fwd + jitter, base_twist, press(), press());
               sent++;
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests.
   // ---------------------------------------------------------------------------------------

   // Registers come out of reset at their documented values.
   task automatic test_register_reset();
      check_all_registers();
   endtask

   // Full-scale sticks, deadband edges and every button combination at reset settings.
   task automatic test_stick_extremes();
      send_tick(STICK_MAX, 0, 1, 0);
      send_tick(STICK_MIN, 0, 0, 1);
      send_tick(STICK_MAX, STICK_MAX, 1, 1);     // both buttons: high gear wins
      send_tick(STICK_MIN, STICK_MIN, 0, 0);     // no button: gear holds
      send_tick(819, 0, 0, 1);                   // right on the deadband edge
      send_tick(820, -820, 0, 0);                // just outside it
      send_tick(-819, 819, 0, 0);
      send_tick(0, 8192, 1, 0);
      send_tick(0, -8192, 0, 0);
      send_tick(8192, 8192, 0, 0);
      send_tick(0, 0, 0, 0);                     // zero target snaps both sides
   endtask

   // Ramp and clamp corners, each behind a register change.
   task automatic test_ramp_corners();
      // Zero step: the gap test passes but the speed does not move.
      write_reg(REG_RAMP_STEP, 0);
      send_tick(8192, 0, 0, 0);
      send_tick(8192, 0, 0, 0);
      send_tick(0, 0, 0, 0);

      // Widest limit and step: jump straight to the clamp, full-scale sticks.
      write_reg(REG_RAMP_STEP, CFG_MAX);
      write_reg(REG_MAX_SPEED, CFG_MAX);
      send_tick(STICK_MAX, STICK_MAX, 0, 0);
      send_tick(STICK_MIN, STICK_MAX, 0, 0);

      // Lowered limit: stored speeds are pulled in on the next tick.
      write_reg(REG_MAX_SPEED, 1000);
      send_tick(8192, 4000, 0, 0);

      // Zero limit holds both sides at rest.
      write_reg(REG_MAX_SPEED, 0);
      send_tick(8192, 0, 1, 0);

      // Gap below the step: the speed holds short of the target.
      write_reg(REG_MAX_SPEED, 8192);
      write_reg(REG_RAMP_STEP, 3000);
      write_reg(REG_DEADBAND, 0);
      send_tick(1000, 0, 0, 0);
      send_tick(5000, 0, 0, 0);
      send_tick(5000, 0, 0, 0);

      // Swap both invert senses.
      write_reg(REG_LEFT_INVERT, 1);
      write_reg(REG_RIGHT_INVERT, 0);
      send_tick(5000, 1000, 0, 0);
      send_tick(5000, 1000, 0, 1);

      // Widest deadband: only the most negative stick value gets through.
      write_reg(REG_DEADBAND, CFG_MAX);
      send_tick(STICK_MAX, STICK_MIN, 0, 0);

      // Writes past the register map and upper data bits are dropped.
      write_reg(REG_SPARE_A, 32'hFFFF_FFFF);
      write_reg(REG_SPARE_B, 32'h0000_0001);
      write_reg(REG_SPARE_C, 32'h0000_2000);
      write_reg(REG_RAMP_STEP, 32'hFFFF_C000 | 32'd410);
      check_all_registers();
   endtask

   // Random traffic under one idling pattern, spread over several register settings.
   task automatic test_random_traffic(input int idle_pct, input int stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (5) run_random_segment(55);
   endtask

   // ---------------------------------------------------------------------------------------
   // Sequence: reset once, directed checks, four idling phases, then drain and report.
   // ---------------------------------------------------------------------------------------
   initial begin
      reset_mixer_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_register_reset();
      test_stick_extremes();
      test_ramp_corners();
      test_random_traffic(0, 0);
      test_random_traffic(79, 0);
      test_random_traffic(0, 79);
      test_random_traffic(32, 32);

      // Drain: wait for every outstanding result, then a short tail for strays.
      req_tvalid <= 1'b0;
      while (pending_drive_cmds.size() != 0)
         @(posedge clock);
      repeat (DRAIN_TAIL) @(posedge clock);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
